// ===== src/ccu_pkg.sv =====
// Shared types and constants for the connected-component union core.
package ccu_pkg;

    localparam int NODE_W = 10;
    localparam int SIZE_W = 11;
    localparam int NODE_SPAN = 2 ** NODE_W;

    localparam logic CMD_UNION = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_LA,
        ST_RD_LB,
        ST_RD_SB,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

// ===== src/connected_component_union_core.sv =====
// Quick-find connected-component tracker with leader and size tables in block memory.
// A query, or a union that merges nothing, gives its word after reading the leaders of node_a and
// node_b (directly when node_a lies beyond the table); a merging union also runs a relabelling scan
// that reads the leader memory one entry per cycle.
// One item is in flight at a time; a finished word waits in the output register.
// After reset a clearing pass fills both memories.
module connected_component_union_core
    import ccu_pkg::*;
#(
    parameter int NODE_COUNT = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              cmd,
    input  logic [NODE_W-1:0] node_a,
    input  logic [NODE_W-1:0] node_b,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [NODE_W-1:0] leader,
    output logic [SIZE_W-1:0] comp_size,
    output logic              merged
);

    localparam int DEPTH = (NODE_COUNT < NODE_SPAN) ? NODE_COUNT : NODE_SPAN;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [NODE_W:0] DEPTH_L = (NODE_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    state_t state_reg, state_next;

    logic [NODE_W-1:0] leader_mem [DEPTH];
    logic [SIZE_W-1:0] size_mem [DEPTH];
    logic [NODE_W-1:0] leader_rd_reg;
    logic [SIZE_W-1:0] size_rd_reg;

    logic [IDX_W-1:0]  leader_raddr, leader_waddr, size_raddr, size_waddr;
    logic [NODE_W-1:0] leader_wdata;
    logic [SIZE_W-1:0] size_wdata;
    logic              leader_we, size_we;

    logic              cmd_reg;
    logic [NODE_W-1:0] b_reg, la_reg, lb_reg;
    logic [SIZE_W-1:0] sa_reg;
    logic [NODE_W-1:0] res_leader_reg;
    logic [SIZE_W-1:0] res_size_reg;
    logic              res_merged_reg;
    logic [IDX_W-1:0]  scan_idx_reg, prev_idx_reg, clr_idx_reg;
    logic              out_valid_reg, merged_out_reg;
    logic [NODE_W-1:0] leader_out_reg;
    logic [SIZE_W-1:0] size_out_reg;

    logic a_in_table, b_in_table, do_merge, out_load, accept;
    logic [SIZE_W-1:0] size_sum;

    assign a_in_table = {1'b0, node_a} < DEPTH_L;
    assign b_in_table = {1'b0, b_reg} < DEPTH_L;
    assign do_merge = (cmd_reg == CMD_UNION) && b_in_table && (la_reg != leader_rd_reg);
    assign size_sum = sa_reg + size_rd_reg;
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);
    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = a_in_table ? ST_RD_LA : ST_FINISH;
                end
            end
            ST_RD_LA:  state_next = ST_RD_LB;
            ST_RD_LB:  state_next = do_merge ? ST_RD_SB : ST_FINISH;
            ST_RD_SB:  state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (prev_idx_reg == LAST_IDX)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        leader_raddr = node_a[IDX_W-1:0];
        leader_waddr = clr_idx_reg;
        leader_wdata = NODE_W'(clr_idx_reg);
        leader_we    = 1'b0;
        size_raddr   = leader_rd_reg[IDX_W-1:0];
        size_waddr   = clr_idx_reg;
        size_wdata   = SIZE_W'(1);
        size_we      = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                leader_we = 1'b1;
                size_we   = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_RD_LA:
            begin
                leader_raddr = b_reg[IDX_W-1:0];
            end
            ST_RD_LB:
            begin
                size_raddr = leader_rd_reg[IDX_W-1:0];
            end
            ST_RD_SB:
            begin
                leader_raddr = '0;
                size_waddr   = la_reg[IDX_W-1:0];
                size_wdata   = size_sum;
                size_we      = 1'b1;
            end
            ST_SCAN:
            begin
                leader_raddr = scan_idx_reg;
                leader_waddr = prev_idx_reg;
                leader_wdata = la_reg;
                leader_we    = (leader_rd_reg == lb_reg);
            end
            ST_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (leader_we)
        begin
            leader_mem[leader_waddr] <= leader_wdata;
        end
        leader_rd_reg <= leader_mem[leader_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (size_we)
        begin
            size_mem[size_waddr] <= size_wdata;
        end
        size_rd_reg <= size_mem[size_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg        <= cmd;
            b_reg          <= node_b;
            res_leader_reg <= node_a;
            res_size_reg   <= SIZE_W'(1);
            res_merged_reg <= 1'b0;
        end
        if (state_reg == ST_RD_LA)
        begin
            la_reg <= leader_rd_reg;
        end
        if (state_reg == ST_RD_LB)
        begin
            lb_reg         <= leader_rd_reg;
            sa_reg         <= size_rd_reg;
            res_leader_reg <= la_reg;
            res_size_reg   <= size_rd_reg;
            res_merged_reg <= 1'b0;
        end
        if (state_reg == ST_RD_SB)
        begin
            res_size_reg   <= size_sum;
            res_merged_reg <= 1'b1;
            scan_idx_reg   <= IDX_W'(1);
            prev_idx_reg   <= '0;
        end
        if (state_reg == ST_SCAN)
        begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            prev_idx_reg <= scan_idx_reg;
        end
        if (out_load)
        begin
            leader_out_reg <= res_leader_reg;
            size_out_reg   <= res_size_reg;
            merged_out_reg <= res_merged_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign leader    = leader_out_reg;
    assign comp_size = size_out_reg;
    assign merged    = merged_out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
    else $error("Input accepted during the clearing pass.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (comp_size != '0))
    else $error("Component size of zero reported.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && merged) |-> (comp_size >= SIZE_W'(2)))
    else $error("Merging union reported a component smaller than two.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && prev_idx_reg == LAST_IDX) |=> (state_reg == ST_FINISH))
    else $error("Relabelling scan did not finish after the last entry.");

endmodule
